### sv/gcai_pkg.sv
`default_nettype none

package gcai_pkg;

  localparam int CW = 32;
  localparam int XW = 65;
  localparam int DW = 98;
  localparam int TW = 131;
  localparam int NW = 31;
  localparam int SW = 64;
  localparam int RW = 32;

  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  typedef logic [2:0][CW-1:0] vec3_t;

  typedef struct packed {
    logic               ok;
    logic               sneg;
    logic [2:0]         tneg;
    logic [2:0][TW-1:0] tmag;
  } tvec_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         neg;
    logic [2:0][NW-1:0] t;
    logic [SW-1:0]      s;
  } nvec_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         neg;
    logic [2:0][NW-1:0] t;
    logic [RW-1:0]      r;
  } rvec_t;

endpackage

`default_nettype wire

### sv/gcai_front.sv
`default_nettype none

module gcai_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  gcai_pkg::vec3_t a_i,
  input  gcai_pkg::vec3_t b_i,
  input  gcai_pkg::vec3_t c_i,
  input  gcai_pkg::vec3_t d_i,
  output logic            valid_o,
  output gcai_pkg::tvec_t data_o
);
  import gcai_pkg::*;

  localparam int NSTG = 9;

  logic [NSTG-1:0] vld_q;
  vec3_t a_q [6];
  vec3_t b_q [6];
  vec3_t c_q [3];
  vec3_t d_q [3];
  logic [5:0] same_q;
  logic signed [63:0] abp_q [3][2];
  logic signed [63:0] cdp_q [3][2];
  logic signed [XW-1:0] abx_q [3];
  logic signed [XW-1:0] cdx_q [3];
  logic signed [XW-1:0] dph_q [4][3];
  logic signed [XW-1:0] dpl_q [4][3];
  logic signed [DW-2:0] dc_q [4][3];
  logic signed [DW-1:0] dot_q [4];
  logic signed [XW:0] tp_q [2][3][3];
  logic signed [TW-2:0] tw_q [2][3];
  logic ok_q, sneg_q, ok8_q, sneg8_q;
  tvec_t out_q;

  vec3_t pt [4];
  logic signed [XW-1:0] vx [4][3];
  vec3_t pm [2];
  logic signed [DW-1:0] wv [2];
  logic signed [TW-1:0] tt [3];
  logic up, un, vp, vn, qp, qn, pp, pn, ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign data_o  = out_q;

  always_comb begin
    pt[0] = a_q[2];
    pt[1] = b_q[2];
    pt[2] = c_q[2];
    pt[3] = d_q[2];
    for (int i = 0; i < 3; i++) begin
      vx[0][i] = cdx_q[i];
      vx[1][i] = cdx_q[i];
      vx[2][i] = abx_q[i];
      vx[3][i] = abx_q[i];
    end
    pm[0] = b_q[5];
    pm[1] = a_q[5];
    wv[0] = dot_q[0];
    wv[1] = dot_q[1];
    up = !dot_q[0][DW-1] && (dot_q[0] != '0);
    un = dot_q[0][DW-1];
    vp = !dot_q[1][DW-1] && (dot_q[1] != '0);
    vn = dot_q[1][DW-1];
    qp = !dot_q[2][DW-1] && (dot_q[2] != '0);
    qn = dot_q[2][DW-1];
    pp = !dot_q[3][DW-1] && (dot_q[3] != '0);
    pn = dot_q[3][DW-1];
    ok_d = !same_q[5] && ((up && vn && qn && pp) || (un && vp && qp && pn));
    for (int i = 0; i < 3; i++) begin
      tt[i] = tw_q[0][i] - tw_q[1][i];
    end
  end

  always_ff @(posedge clk_i) begin
    a_q[0]    <= a_i;
    b_q[0]    <= b_i;
    c_q[0]    <= c_i;
    d_q[0]    <= d_i;
    same_q[0] <= (a_i == c_i) || (a_i == d_i) || (b_i == c_i) || (b_i == d_i);
    for (int k = 1; k < 6; k++) begin
      a_q[k]    <= a_q[k-1];
      b_q[k]    <= b_q[k-1];
      same_q[k] <= same_q[k-1];
    end
    for (int k = 1; k < 3; k++) begin
      c_q[k] <= c_q[k-1];
      d_q[k] <= d_q[k-1];
    end
    // cross product terms
    for (int i = 0; i < 3; i++) begin
      abp_q[i][0] <= $signed(a_q[0][NX1[i]]) * $signed(b_q[0][NX2[i]]);
      abp_q[i][1] <= $signed(a_q[0][NX2[i]]) * $signed(b_q[0][NX1[i]]);
      cdp_q[i][0] <= $signed(c_q[0][NX1[i]]) * $signed(d_q[0][NX2[i]]);
      cdp_q[i][1] <= $signed(c_q[0][NX2[i]]) * $signed(d_q[0][NX1[i]]);
      abx_q[i]    <= abp_q[i][0] - abp_q[i][1];
      cdx_q[i]    <= cdp_q[i][0] - cdp_q[i][1];
    end
    // dot products, split in high and low halves
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        dph_q[d][i] <= $signed(pt[d][i]) * $signed(vx[d][i][XW-1:32]);
        dpl_q[d][i] <= $signed(pt[d][i]) * $signed({1'b0, vx[d][i][31:0]});
        dc_q[d][i]  <= $signed({dph_q[d][i], 32'd0}) + dpl_q[d][i];
      end
      dot_q[d] <= dc_q[d][0] + dc_q[d][1] + dc_q[d][2];
    end
    ok_q   <= ok_d;
    sneg_q <= un;
    // T = B*u - A*v, u and v split in three chunks
    for (int m = 0; m < 2; m++) begin
      for (int i = 0; i < 3; i++) begin
        tp_q[m][i][0] <= $signed(pm[m][i]) * $signed({1'b0, wv[m][31:0]});
        tp_q[m][i][1] <= $signed(pm[m][i]) * $signed({1'b0, wv[m][63:32]});
        tp_q[m][i][2] <= $signed(pm[m][i]) * $signed(wv[m][DW-1:64]);
        tw_q[m][i]    <= $signed({tp_q[m][i][2], 64'd0}) +
                         $signed({tp_q[m][i][1], 32'd0}) + tp_q[m][i][0];
      end
    end
    ok8_q      <= ok_q;
    sneg8_q    <= sneg_q;
    out_q.ok   <= ok8_q;
    out_q.sneg <= sneg8_q;
    for (int i = 0; i < 3; i++) begin
      out_q.tneg[i] <= tt[i][TW-1];
      out_q.tmag[i] <= tt[i][TW-1] ? TW'(-tt[i]) : TW'(tt[i]);
    end
  end

endmodule

`default_nettype wire

### sv/gcai_norm.sv
`default_nettype none

module gcai_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  gcai_pkg::tvec_t data_i,
  output logic            valid_o,
  output gcai_pkg::nvec_t data_o
);
  import gcai_pkg::*;

  localparam int NSTG  = 6;
  localparam int NSTEP = $clog2(TW);
  localparam int LO [3] = '{0, 3, 6};
  localparam int HI [3] = '{3, 6, NSTEP};

  typedef logic [3:0][TW-1:0] shv_t;

  function automatic shv_t nstep(input shv_t v, input int sh);
    shv_t r;
    r = v;
    if ((v[3] >> (TW - sh)) == '0) begin
      for (int k = 0; k < 4; k++) begin
        r[k] = v[k] << sh;
      end
    end
    return r;
  endfunction

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] ok_q;
  logic [2:0] neg_q [NSTG];
  shv_t sv_q [3];
  logic [NW-1:0] t_q [2][3];
  logic [2*NW-1:0] sq_q [3];
  nvec_t out_q;
  logic [TW-1:0] orv;

  assign orv     = data_i.tmag[0] | data_i.tmag[1] | data_i.tmag[2];
  assign valid_o = vld_q[NSTG-1];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < 3; s++) begin : g_sh
    shv_t vin, vout;
    if (s == 0) begin : g_first
      assign vin = {orv, data_i.tmag[2], data_i.tmag[1], data_i.tmag[0]};
    end else begin : g_next
      assign vin = sv_q[s-1];
    end
    always_comb begin
      vout = vin;
      for (int j = 0; j < NSTEP; j++) begin
        if (j >= LO[s] && j < HI[s]) begin
          vout = nstep(vout, 1 << (NSTEP - 1 - j));
        end
      end
    end
    always_ff @(posedge clk_i) begin
      sv_q[s] <= vout;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q[0]  <= data_i.ok && (orv != '0);
    neg_q[0] <= data_i.tneg ^ {3{data_i.sneg}};
    for (int k = 1; k < NSTG; k++) begin
      ok_q[k]  <= ok_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      t_q[0][i] <= sv_q[2][i][TW-1 -: NW];
      t_q[1][i] <= t_q[0][i];
      sq_q[i]   <= t_q[0][i] * t_q[0][i];
      out_q.t[i] <= t_q[1][i];
    end
    out_q.s   <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    out_q.ok  <= ok_q[NSTG-2];
    out_q.neg <= neg_q[NSTG-2];
  end

endmodule

`default_nettype wire

### sv/gcai_sqrt.sv
`default_nettype none

module gcai_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  gcai_pkg::nvec_t data_i,
  output logic            valid_o,
  output gcai_pkg::rvec_t data_o
);
  import gcai_pkg::*;

  localparam int PER = 4;
  localparam int NST = RW / PER;

  typedef struct packed {
    logic               ok;
    logic [2:0]         neg;
    logic [2:0][NW-1:0] t;
    logic [SW-1:0]      s;
    logic [RW+2:0]      rem;
    logic [RW-1:0]      root;
  } sq_t;

  logic [NST-1:0] vld_q;
  sq_t st_q [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    sq_t vin, vout;
    logic [RW+2:0] sh;
    logic [RW+2:0] trial;
    if (s == 0) begin : g_first
      always_comb begin
        vin      = '0;
        vin.ok   = data_i.ok;
        vin.neg  = data_i.neg;
        vin.t    = data_i.t;
        vin.s    = data_i.s;
      end
    end else begin : g_next
      assign vin = st_q[s-1];
    end
    always_comb begin
      vout  = vin;
      sh    = '0;
      trial = '0;
      for (int j = 0; j < PER; j++) begin
        sh    = {vout.rem[RW:0], vout.s[SW-1 -: 2]};
        trial = {1'b0, vout.root, 2'b01};
        vout.s = vout.s << 2;
        if (sh >= trial) begin
          vout.rem  = sh - trial;
          vout.root = {vout.root[RW-2:0], 1'b1};
        end else begin
          vout.rem  = sh;
          vout.root = {vout.root[RW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      st_q[s] <= vout;
    end
  end

  assign valid_o    = vld_q[NST-1];
  assign data_o.ok  = st_q[NST-1].ok;
  assign data_o.neg = st_q[NST-1].neg;
  assign data_o.t   = st_q[NST-1].t;
  assign data_o.r   = st_q[NST-1].root;

endmodule

`default_nettype wire

### sv/gcai_div.sv
`default_nettype none

module gcai_div #(
  parameter int FRAC_BITS = 30
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  gcai_pkg::rvec_t                  data_i,
  output logic                             valid_o,
  output logic                             hit_o,
  output logic [2:0][gcai_pkg::CW-1:0]     res_o
);
  import gcai_pkg::*;

  localparam int QW    = FRAC_BITS + 2;
  localparam int STEPS = FRAC_BITS + 1;
  localparam int PER   = 4;
  localparam int NST   = (STEPS + PER - 1) / PER;
  localparam int NSTG  = NST + 2;
  localparam int MW    = (QW > CW + 1) ? QW : CW + 1;
  localparam logic [MW-1:0] LIM_P = {{(MW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [MW-1:0] LIM_N = LIM_P + 1'b1;

  typedef struct packed {
    logic               ok;
    logic [2:0]         neg;
    logic [RW-1:0]      r;
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] quo;
  } dv_t;

  logic [NSTG-1:0] vld_q;
  dv_t st_q [NST+1];
  dv_t init_d;
  logic hit_q;
  logic [2:0][CW-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_comb begin
    init_d     = '0;
    init_d.ok  = data_i.ok && (data_i.r != '0);
    init_d.neg = data_i.neg;
    init_d.r   = data_i.r;
    for (int i = 0; i < 3; i++) begin
      if (RW'(data_i.t[i]) >= data_i.r) begin
        init_d.quo[i] = QW'(1);
        init_d.rem[i] = RW'(data_i.t[i]) - data_i.r;
      end else begin
        init_d.quo[i] = '0;
        init_d.rem[i] = RW'(data_i.t[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= init_d;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    dv_t vout;
    logic [RW:0] sh;
    always_comb begin
      vout = st_q[s];
      sh   = '0;
      for (int j = 0; j < PER; j++) begin
        if (s * PER + j < STEPS) begin
          for (int i = 0; i < 3; i++) begin
            sh = {vout.rem[i], 1'b0};
            if (sh >= {1'b0, vout.r}) begin
              vout.rem[i] = RW'(sh - {1'b0, vout.r});
              vout.quo[i] = {vout.quo[i][QW-2:0], 1'b1};
            end else begin
              vout.rem[i] = sh[RW-1:0];
              vout.quo[i] = {vout.quo[i][QW-2:0], 1'b0};
            end
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      st_q[s+1] <= vout;
    end
  end

  // round half up, saturate, apply sign
  always_ff @(posedge clk_i) begin
    logic [QW:0]   mq;
    logic [MW-1:0] mg;
    logic [CW-1:0] lo;
    hit_q <= st_q[NST].ok;
    for (int i = 0; i < 3; i++) begin
      mq = {1'b0, st_q[NST].quo[i]} + 1'b1;
      mg = MW'(mq[QW:1]);
      if (st_q[NST].neg[i]) begin
        if (mg > LIM_N) begin
          mg = LIM_N;
        end
        lo = mg[CW-1:0];
        lo = ~lo + 1'b1;
      end else begin
        if (mg > LIM_P) begin
          mg = LIM_P;
        end
        lo = mg[CW-1:0];
      end
      res_q[i] <= st_q[NST].ok ? lo : '0;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign hit_o   = hit_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

### sv/great_circle_arc_intersection_top.sv
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Depth comes from the front end, normalization, the 8-stage square root and the 4-bit-per-stage divider.
// Reset (rst_ni, async, active low) clears all valid bits; no result is emitted
// for words in flight at reset.
`default_nettype none

module great_circle_arc_intersection_top #(
  parameter int FRAC_BITS = 30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [gcai_pkg::CW-1:0] a_x_i,
  input  logic signed [gcai_pkg::CW-1:0] a_y_i,
  input  logic signed [gcai_pkg::CW-1:0] a_z_i,
  input  logic signed [gcai_pkg::CW-1:0] b_x_i,
  input  logic signed [gcai_pkg::CW-1:0] b_y_i,
  input  logic signed [gcai_pkg::CW-1:0] b_z_i,
  input  logic signed [gcai_pkg::CW-1:0] c_x_i,
  input  logic signed [gcai_pkg::CW-1:0] c_y_i,
  input  logic signed [gcai_pkg::CW-1:0] c_z_i,
  input  logic signed [gcai_pkg::CW-1:0] d_x_i,
  input  logic signed [gcai_pkg::CW-1:0] d_y_i,
  input  logic signed [gcai_pkg::CW-1:0] d_z_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic signed [gcai_pkg::CW-1:0] out_x_o,
  output logic signed [gcai_pkg::CW-1:0] out_y_o,
  output logic signed [gcai_pkg::CW-1:0] out_z_o
);
  import gcai_pkg::*;

  logic  accept;
  vec3_t a, b, c, d;
  logic  tv_valid, nv_valid, rv_valid;
  tvec_t tv;
  nvec_t nv;
  rvec_t rv;
  logic [2:0][CW-1:0] res;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign a = {a_z_i, a_y_i, a_x_i};
  assign b = {b_z_i, b_y_i, b_x_i};
  assign c = {c_z_i, c_y_i, c_x_i};
  assign d = {d_z_i, d_y_i, d_x_i};

  gcai_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .a_i     (a),
    .b_i     (b),
    .c_i     (c),
    .d_i     (d),
    .valid_o (tv_valid),
    .data_o  (tv)
  );

  gcai_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_valid),
    .data_i  (tv),
    .valid_o (nv_valid),
    .data_o  (nv)
  );

  gcai_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nv_valid),
    .data_i  (nv),
    .valid_o (rv_valid),
    .data_o  (rv)
  );

  gcai_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_valid),
    .data_i  (rv),
    .valid_o (done_o),
    .hit_o   (hit_o),
    .res_o   (res)
  );

  assign out_x_o = $signed(res[0]);
  assign out_y_o = $signed(res[1]);
  assign out_z_o = $signed(res[2]);

endmodule

`default_nettype wire

### dv/gcai_result_monitor.sv
`default_nettype none

module gcai_result_monitor #(
  parameter int FRAC_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [gcai_pkg::CW-1:0] pts_i [12],
  input  logic                    done_i,
  input  logic                    hit_i,
  input  logic [gcai_pkg::CW-1:0] out_x_i,
  input  logic [gcai_pkg::CW-1:0] out_y_i,
  input  logic [gcai_pkg::CW-1:0] out_z_i,
  output int                      fail_cnt_o,
  output int                      pending_o,
  output int                      hit_cnt_o,
  output int                      word_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [199:0] big_t;

  typedef struct {
    logic        hit;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic big_t dot3(input big_t p [3], input big_t q [3]);
    return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic crossing_t predict_crossing(input logic [31:0] w [12]);
    crossing_t   o;
    big_t        pt [4][3];
    big_t        abx [3];
    big_t        cdx [3];
    big_t        tv [3];
    big_t        mag [3];
    big_t        u, v, q, p;
    logic [63:0] t [3];
    logic [63:0] s, r;
    logic [127:0] num, quo, m;
    int          k, sgn;
    logic        neg;
    o = '{1'b0, '0, '0, '0};
    for (int i = 0; i < 12; i++) pt[i / 3][i % 3] = big_t'($signed(w[i]));
    for (int i = 0; i < 2; i++) begin
      for (int j = 2; j < 4; j++) begin
        if (pt[i][0] == pt[j][0] && pt[i][1] == pt[j][1] && pt[i][2] == pt[j][2])
          return o;
      end
    end
    for (int i = 0; i < 3; i++) begin
      abx[i] = pt[0][(i + 1) % 3] * pt[1][(i + 2) % 3] - pt[0][(i + 2) % 3] * pt[1][(i + 1) % 3];
      cdx[i] = pt[2][(i + 1) % 3] * pt[3][(i + 2) % 3] - pt[2][(i + 2) % 3] * pt[3][(i + 1) % 3];
    end
    u = dot3(pt[0], cdx);
    v = dot3(pt[1], cdx);
    q = dot3(pt[2], abx);
    p = dot3(pt[3], abx);
    k = 0;
    for (int i = 0; i < 3; i++) begin
      tv[i] = pt[1][i] * u - pt[0][i] * v;
      mag[i] = tv[i] < 0 ? -tv[i] : tv[i];
      for (int b = 199; b >= 0; b--) begin
        if (mag[i][b]) begin
          if (b + 1 > k) k = b + 1;
          break;
        end
      end
    end
    if (k == 0) return o;
    sgn = u > 0 ? 1 : (u < 0 ? -1 : 0);
    if (sgn == 0) return o;
    if ((v > 0 ? -1 : (v < 0 ? 1 : 0)) != sgn) return o;
    if ((q > 0 ? -1 : (q < 0 ? 1 : 0)) != sgn) return o;
    if ((p > 0 ? 1 : (p < 0 ? -1 : 0)) != sgn) return o;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      if (k > 31) t[i] = 64'(mag[i] >> (k - 31));
      else t[i] = 64'(mag[i]) << (31 - k);
      s = s + t[i] * t[i];
    end
    r = floor_sqrt(s);
    if (r == 0) return o;
    o.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      num = 128'(t[i]) << (FRAC_BITS + 1);
      quo = num / 128'(r);
      m = (quo + 1) >> 1;
      neg = ((tv[i] < 0) != (sgn < 0)) && t[i] != 0;
      if (neg) begin
        if (m > 128'h8000_0000) m = 128'h8000_0000;
        m = -m;
      end else if (m > 128'h7FFF_FFFF) begin
        m = 128'h7FFF_FFFF;
      end
      if (i == 0) o.x = m[31:0];
      else if (i == 1) o.y = m[31:0];
      else o.z = m[31:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on word %0d: %s got %h want %h", word_cnt_o, what, got, want);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    hit_cnt_o  = 0;
    word_cnt_o = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (crossing_q.size() == 0) begin
          $display("result with nothing outstanding");
          fail_cnt_o++;
        end else begin
          want = crossing_q.pop_front();
          if (hit_i !== want.hit) report_mismatch("hit", 32'(hit_i), 32'(want.hit));
          if (out_x_i !== want.x) report_mismatch("out_x", out_x_i, want.x);
          if (out_y_i !== want.y) report_mismatch("out_y", out_y_i, want.y);
          if (out_z_i !== want.z) report_mismatch("out_z", out_z_i, want.z);
          if (want.hit) hit_cnt_o++;
          word_cnt_o++;
        end
      end
      if (start && !busy) crossing_q.push_back(predict_crossing(pts_i));
    end
    pending_o = crossing_q.size();
  end

endmodule

`default_nettype wire

### dv/tb_great_circle_arc_intersection_top.sv
`default_nettype none

module tb_great_circle_arc_intersection_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ONE = 32'h4000_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] pts [12];
  logic        done_o, hit_o;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  int          fail_cnt, pending, hit_cnt, word_cnt;
  int          sent = 0;
  bit          calm = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  great_circle_arc_intersection_top u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .a_x_i(pts[0]), .a_y_i(pts[1]), .a_z_i(pts[2]),
    .b_x_i(pts[3]), .b_y_i(pts[4]), .b_z_i(pts[5]),
    .c_x_i(pts[6]), .c_y_i(pts[7]), .c_z_i(pts[8]),
    .d_x_i(pts[9]), .d_y_i(pts[10]), .d_z_i(pts[11]),
    .done_o, .hit_o, .out_x_o, .out_y_o, .out_z_o
  );

  gcai_result_monitor u_mon (
    .clk_i, .rst_ni, .start, .busy, .pts_i(pts),
    .done_i(done_o), .hit_i(hit_o), .out_x_i(out_x_o), .out_y_i(out_y_o),
    .out_z_i(out_z_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .hit_cnt_o(hit_cnt), .word_cnt_o(word_cnt)
  );

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [31:0] w [12]);
    int gap;
    bit took;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pts = w;
    start = 1'b1;
    took = 0;
    while (!took) begin
      took = !busy;
      @(negedge clk_i);
    end
    sent++;
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 32'h7FFF_FFFE)) - 32'sh3FFF_FFFF);
    endcase
  endfunction

  task automatic send_pts(input logic [31:0] a [3], input logic [31:0] b [3],
                          input logic [31:0] c [3], input logic [31:0] d [3]);
    logic [31:0] w [12];
    for (int i = 0; i < 3; i++) begin
      w[i] = a[i];
      w[3 + i] = b[i];
      w[6 + i] = c[i];
      w[9 + i] = d[i];
    end
    send_word(w);
  endtask

  initial begin
    logic [31:0] w [12];
    logic [31:0] a [3], b [3], c [3], d [3];
    int mode;
    for (int i = 0; i < 12; i++) pts[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // crossing at the quarter circle
    send_pts('{ONE, 0, 0}, '{0, ONE, 0}, '{ONE, ONE, -ONE}, '{ONE, ONE, ONE});
    // same arcs, swapped order: still a crossing
    send_pts('{ONE, ONE, -ONE}, '{ONE, ONE, ONE}, '{ONE, 0, 0}, '{0, ONE, 0});
    send_pts('{ONE, 0, 0}, '{0, ONE, 0}, '{-ONE, -ONE, -ONE}, '{-ONE, -ONE, ONE});
    // shared endpoints
    send_pts('{ONE, 0, 0}, '{0, ONE, 0}, '{ONE, 0, 0}, '{0, 0, ONE});
    send_pts('{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}, '{0, ONE, 0});
    // coplanar arcs, zero-length crossing direction
    send_pts('{ONE, 0, 0}, '{0, ONE, 0}, '{ONE / 2, 0, 0}, '{0, ONE / 2, 0});
    send_pts('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
    send_pts('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE});
    // field extremes
    for (int i = 0; i < 12; i++) w[i] = 32'h7FFF_FFFF;
    send_word(w);
    for (int i = 0; i < 12; i++) w[i] = 32'h8000_0000;
    send_word(w);
    send_pts('{32'h7FFF_FFFF, 32'h8000_0000, 0}, '{32'h8000_0000, 32'h7FFF_FFFF, 1},
             '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
             '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_pts('{32'h8000_0000, 0, 0}, '{0, 32'h8000_0000, 0},
             '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
             '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    // tiny codes take the left-shift path of normalization
    send_pts('{1, 0, 0}, '{0, 1, 0}, '{1, 1, -1}, '{1, 1, 1});
    send_pts('{2, 0, 0}, '{0, 3, 0}, '{1, 2, -1}, '{1, 1, 1});

    for (int n = 0; n < 1400; n++) begin
      if (n % 250 == 0) calm = !calm;
      if (n == 700) begin
        start = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
        b[i] = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
        c[i] = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
        d[i] = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
      end
      // straddle arc AB: C and D on opposite sides near its midpoint
      if (mode >= 5 && mode <= 8) begin
        for (int i = 0; i < 3; i++) begin
          c[i] = ($signed(a[i]) >>> 1) + ($signed(b[i]) >>> 1) + ($signed(c[i]) >>> 3);
          d[i] = ($signed(a[i]) >>> 1) + ($signed(b[i]) >>> 1) - ($signed(c[i]) >>> 2);
        end
      end
      if (mode == 9) begin
        if ($urandom_range(0, 1)) c = a;
        else d = b;
      end
      send_pts(a, b, c, d);
    end
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("sent %0d words, checked %0d results, %0d crossings", sent, word_cnt, hit_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("** great_circle_arc_intersection_top: PASSED **");
    end else begin
      $display("** great_circle_arc_intersection_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("** great_circle_arc_intersection_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
